// ===== hw/rtl/pbfd_pkg.sv =====
// Shared types and constants for the preset bus frame decoder.
// No dependencies; used by the decoder, the top level and the checker.
`default_nettype none

package pbfd_pkg;

  // bus event kinds carried in in_tuser
  typedef enum logic [2:0] {
    MODE_DATA       = 3'd0,
    MODE_START      = 3'd1,
    MODE_STOP       = 3'd2,
    MODE_OVERFLOW   = 3'd3,
    MODE_JOB_DONE   = 3'd4,
    MODE_REPLY_SENT = 3'd5
  } mode_t;

  // result kinds carried in out_tuser
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_CMD  = 2'd1,
    KIND_DROP = 2'd2
  } kind_t;

  // decoded command codes
  typedef enum logic [3:0] {
    CMD_RECALL     = 4'd0,
    CMD_SAVE       = 4'd1,
    CMD_POLL       = 4'd2,
    CMD_REMOTE_ON  = 4'd3,
    CMD_REMOTE_OFF = 4'd4,
    CMD_QUERY      = 4'd5,
    CMD_ENUM       = 4'd6,
    CMD_BACKUP     = 4'd7,
    CMD_RESTORE    = 4'd8,
    CMD_MIDI       = 4'd9,
    CMD_CLOCK      = 4'd10,
    CMD_UNKNOWN    = 4'd11
  } cmd_t;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_MODULE_ADDRESS = 1'b0,
    CFG_REMOTE_DEFAULT = 1'b1
  } cfg_idx_t;

  // long framing marker and subcommands
  localparam logic [7:0] LONG_MARK      = 8'h22;
  localparam logic [7:0] SUB_RECALL     = 8'h01;
  localparam logic [7:0] SUB_SAVE       = 8'h02;
  localparam logic [7:0] SUB_BACKUP     = 8'h04;
  localparam logic [7:0] SUB_RESTORE    = 8'h05;
  localparam logic [7:0] SUB_POLL       = 8'h14;
  localparam logic [7:0] SUB_REMOTE_ON  = 8'h16;
  localparam logic [7:0] SUB_REMOTE_OFF = 8'h17;
  localparam logic [7:0] SUB_QUERY      = 8'h1A;
  localparam logic [7:0] SUB_ENUM       = 8'h1B;

  // short framing command bytes
  localparam logic [7:0] SHORT_RECALL     = 8'h00;
  localparam logic [7:0] SHORT_SAVE       = 8'h01;
  localparam logic [7:0] SHORT_REMOTE_ON  = 8'h14;
  localparam logic [7:0] SHORT_REMOTE_OFF = 8'h15;
  localparam logic [7:0] SHORT_BACKUP     = 8'h2D;
  localparam logic [7:0] SHORT_RESTORE    = 8'h2E;
  localparam logic [7:0] STATUS_MASK      = 8'h80;
  localparam logic [7:0] CLOCK_FLOOR      = 8'hF8;

  // frame lengths that matter to decoding
  localparam logic [7:0] LEN_LONG_MIN   = 8'd4;
  localparam logic [7:0] LEN_LONG_CARD  = 8'd8;
  localparam logic [7:0] LEN_SHORT_SLOT = 8'd2;
  localparam logic [7:0] LEN_SHORT_ONE  = 8'd1;
  localparam logic [7:0] LEN_SHORT_CARD = 8'd5;

  // number of leading frame bytes the decoder looks at
  localparam int DEC_BYTES = 8;

  // result payload, command code in the lowest bits
  typedef struct packed {
    logic        reply_owed;
    logic        remote_on;
    logic        job_refused;
    logic        job_start;
    logic        save_strobe;
    logic        recall_strobe;
    logic [15:0] memory_offset;
    logic [7:0]  card_low;
    logic [7:0]  target_module;
    logic [7:0]  argument;
    cmd_t        command_code;
  } res_t;

  localparam int RES_W       = $bits(res_t);
  localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

  // bit positions inside out_tdata
  localparam int POS_RECALL  = 44;
  localparam int POS_SAVE    = 45;
  localparam int POS_START   = 46;
  localparam int POS_REFUSED = 47;
  localparam int POS_REMOTE  = 48;

  // state changes asked for by a decoded command
  typedef struct packed {
    logic remote_set;
    logic remote_clr;
    logic reply_set;
    logic job_set;
  } eff_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pbfd_decode.sv =====
// Frame decoder: long and short framings plus command side effects.
// Depends on pbfd_pkg; purely combinational, instantiated by the top level.
`default_nettype none

module pbfd_decode #(
  parameter int SLOT_TOTAL = 64,
  parameter int CNT_W      = 4
) (
  input  wire logic [pbfd_pkg::DEC_BYTES-1:0][7:0] fb,
  input  wire logic [CNT_W-1:0]                    count,
  input  wire logic [7:0]                          module_address,
  input  wire logic                                remote_state,
  input  wire logic                                job_busy,
  output pbfd_pkg::res_t                           dec,
  output pbfd_pkg::eff_t                           eff
);

  localparam logic [8:0] SLOT_LIM = 9'(SLOT_TOTAL);

  logic [7:0]     n8;
  logic           long_ok;
  pbfd_pkg::cmd_t cmd;
  logic [7:0]     arg;
  logic [7:0]     tgt;
  logic [7:0]     card;
  logic [15:0]    mem;
  logic           slot_ok;
  logic           addr_hit;

  assign n8      = 8'(count);
  assign long_ok = (n8 >= pbfd_pkg::LEN_LONG_MIN) && (fb[2] == pbfd_pkg::LONG_MARK) &&
                   (fb[0] == n8 - 8'd1);

  // framing decode
  always_comb begin
    cmd  = pbfd_pkg::CMD_UNKNOWN;
    arg  = '0;
    tgt  = '0;
    card = '0;
    mem  = '0;
    if (long_ok) begin
      tgt = fb[1];
      arg = fb[3];
      case (fb[3])
        pbfd_pkg::SUB_RECALL: begin
          cmd = pbfd_pkg::CMD_RECALL;
          arg = (n8 > pbfd_pkg::LEN_LONG_MIN) ? fb[4] : 8'd0;
        end
        pbfd_pkg::SUB_SAVE: begin
          cmd = pbfd_pkg::CMD_SAVE;
          arg = (n8 > pbfd_pkg::LEN_LONG_MIN) ? fb[4] : 8'd0;
        end
        pbfd_pkg::SUB_POLL: begin
          cmd = pbfd_pkg::CMD_POLL;
          arg = '0;
        end
        pbfd_pkg::SUB_REMOTE_ON: begin
          cmd = pbfd_pkg::CMD_REMOTE_ON;
          arg = '0;
        end
        pbfd_pkg::SUB_REMOTE_OFF: begin
          cmd = pbfd_pkg::CMD_REMOTE_OFF;
          arg = '0;
        end
        pbfd_pkg::SUB_QUERY: begin
          cmd = pbfd_pkg::CMD_QUERY;
          arg = '0;
        end
        pbfd_pkg::SUB_ENUM: begin
          cmd = pbfd_pkg::CMD_ENUM;
          arg = '0;
        end
        pbfd_pkg::SUB_BACKUP, pbfd_pkg::SUB_RESTORE: begin
          // card transfer needs the full eight-byte frame
          if (n8 >= pbfd_pkg::LEN_LONG_CARD) begin
            cmd  = (fb[3] == pbfd_pkg::SUB_BACKUP) ? pbfd_pkg::CMD_BACKUP :
                                                      pbfd_pkg::CMD_RESTORE;
            arg  = '0;
            tgt  = fb[4];
            card = fb[5];
            mem  = {fb[7], fb[6]};
          end
        end
        default: begin
          cmd = pbfd_pkg::CMD_UNKNOWN;
        end
      endcase
    end else begin
      arg = fb[0];
      case (fb[0])
        pbfd_pkg::SHORT_RECALL: begin
          if (n8 == pbfd_pkg::LEN_SHORT_SLOT) begin
            cmd = pbfd_pkg::CMD_RECALL;
            arg = fb[1];
          end
        end
        pbfd_pkg::SHORT_SAVE: begin
          if (n8 == pbfd_pkg::LEN_SHORT_SLOT) begin
            cmd = pbfd_pkg::CMD_SAVE;
            arg = fb[1];
          end
        end
        pbfd_pkg::SHORT_REMOTE_ON: begin
          if (n8 == pbfd_pkg::LEN_SHORT_ONE) begin
            cmd = pbfd_pkg::CMD_REMOTE_ON;
            arg = '0;
          end
        end
        pbfd_pkg::SHORT_REMOTE_OFF: begin
          if (n8 == pbfd_pkg::LEN_SHORT_ONE) begin
            cmd = pbfd_pkg::CMD_REMOTE_OFF;
            arg = '0;
          end
        end
        pbfd_pkg::SHORT_BACKUP, pbfd_pkg::SHORT_RESTORE: begin
          if (n8 == pbfd_pkg::LEN_SHORT_CARD) begin
            cmd  = (fb[0] == pbfd_pkg::SHORT_BACKUP) ? pbfd_pkg::CMD_BACKUP :
                                                        pbfd_pkg::CMD_RESTORE;
            arg  = '0;
            tgt  = fb[1];
            mem  = {fb[3], fb[2]};
            card = fb[4];
          end
        end
        default: begin
          // midi status and realtime bytes
          if ((fb[0] & pbfd_pkg::STATUS_MASK) != 8'd0) begin
            cmd = (fb[0] >= pbfd_pkg::CLOCK_FLOOR) ? pbfd_pkg::CMD_CLOCK :
                                                     pbfd_pkg::CMD_MIDI;
          end
        end
      endcase
    end
  end

  assign slot_ok  = remote_state && ({1'b0, arg} < SLOT_LIM);
  assign addr_hit = (tgt == module_address);

  // side effects of the decoded command
  always_comb begin
    dec               = '0;
    dec.command_code  = cmd;
    dec.argument      = arg;
    dec.target_module = tgt;
    dec.card_low      = card;
    dec.memory_offset = mem;
    eff               = '0;
    case (cmd)
      pbfd_pkg::CMD_REMOTE_ON:  eff.remote_set = 1'b1;
      pbfd_pkg::CMD_REMOTE_OFF: eff.remote_clr = 1'b1;
      pbfd_pkg::CMD_RECALL:     dec.recall_strobe = slot_ok;
      pbfd_pkg::CMD_SAVE:       dec.save_strobe = slot_ok;
      pbfd_pkg::CMD_BACKUP, pbfd_pkg::CMD_RESTORE: begin
        if (addr_hit) begin
          dec.job_refused = job_busy;
          dec.job_start   = !job_busy;
          eff.job_set     = !job_busy;
        end
      end
      pbfd_pkg::CMD_QUERY:      eff.reply_set = addr_hit;
      pbfd_pkg::CMD_ENUM:       eff.reply_set = 1'b1;
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/preset_bus_frame_decoder_core.sv =====
// Top level of the preset bus frame decoder: input stage, frame buffer, state, result stage.
// Depends on pbfd_pkg and pbfd_decode.
`default_nettype none

// One bus event per cycle is taken unless out_tready stalls the result stage.
// An accepted request is handled straight from the input register, against
// the frame buffer and state, once the output register is free, and its
// single result is loaded into the output register at the end of that cycle,
// raising out_tvalid. Fully pipelined, with stalls on out_tready passing
// straight back to in_tready. Every event gives exactly one result, most of
// kind nothing.
// remote_state takes the remote_default register value while rst_n is low;
// hold reset until remote_state has taken the cleared remote_default value.
// Both ready outputs stay low while rst_n is low. Configuration writes are
// taken every cycle out of reset and should be made while idle.
module preset_bus_frame_decoder_core #(
  parameter int FRAME_BYTES = 12,
  parameter int SLOT_TOTAL  = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input channel
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [7:0]                       in_tdata,  // [7:0] data_byte
  input  wire logic [2:0]                       in_tuser,  // [2:0] mode
  // result channel
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [3:0] command_code, [11:4] argument, [19:12] target_module, [27:20] card_low,
  // [43:28] memory_offset, [44] recall_strobe, [45] save_strobe, [46] job_start,
  // [47] job_refused, [48] remote_on, [49] reply_owed, rest zero
  output logic [pbfd_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic [1:0]                            out_tuser, // [1:0] result_kind
  // configuration write channel
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [0:0]                       cfg_index,
  input  wire logic [7:0]                       cfg_data
);

  localparam int CNT_W = $clog2(FRAME_BYTES + 1);
  localparam int IDX_W = $clog2(FRAME_BYTES);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(FRAME_BYTES);

  // configuration registers
  logic [7:0] module_address_r;
  logic       remote_default_r;

  // input stage
  logic       in_valid_r;
  logic [2:0] mode_r;
  logic [7:0] byte_r;
  logic       advance;

  // frame and command state
  logic [7:0]       frame_bytes_r [FRAME_BYTES];
  logic [CNT_W-1:0] frame_count_r, frame_count_nxt;
  logic             frame_open_r, frame_open_nxt;
  logic             frame_bad_r, frame_bad_nxt;
  logic             remote_state_r, remote_state_nxt;
  logic             reply_flag_r, reply_flag_nxt;
  logic             job_busy_r, job_busy_nxt;
  logic             byte_we;

  // result stage
  logic                   out_valid_r;
  pbfd_pkg::kind_t        out_kind_r, kind_nxt;
  pbfd_pkg::res_t         out_res_r, res_nxt;

  logic [pbfd_pkg::DEC_BYTES-1:0][7:0] dec_bytes;
  pbfd_pkg::res_t dec;
  pbfd_pkg::eff_t eff;

  assign cfg_ready = rst_n;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      module_address_r <= '0;
      remote_default_r <= 1'b0;
    end else if (cfg_valid) begin
      case (pbfd_pkg::cfg_idx_t'(cfg_index))
        pbfd_pkg::CFG_MODULE_ADDRESS: module_address_r <= cfg_data;
        pbfd_pkg::CFG_REMOTE_DEFAULT: remote_default_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // handshake: result register frees when taken, input register when handled
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = rst_n && (!in_valid_r || advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      mode_r <= in_tuser;
      byte_r <= in_tdata;
    end
  end

  // leading frame bytes seen by the decoder
  always_comb begin
    for (int i = 0; i < pbfd_pkg::DEC_BYTES; i++) begin
      dec_bytes[i] = frame_bytes_r[i];
    end
  end

  pbfd_decode #(
    .SLOT_TOTAL (SLOT_TOTAL),
    .CNT_W      (CNT_W)
  ) u_decode (
    .fb             (dec_bytes),
    .count          (frame_count_r),
    .module_address (module_address_r),
    .remote_state   (remote_state_r),
    .job_busy       (job_busy_r),
    .dec            (dec),
    .eff            (eff)
  );

  // event handling
  always_comb begin
    frame_count_nxt  = frame_count_r;
    frame_open_nxt   = frame_open_r;
    frame_bad_nxt    = frame_bad_r;
    remote_state_nxt = remote_state_r;
    reply_flag_nxt   = reply_flag_r;
    job_busy_nxt     = job_busy_r;
    byte_we          = 1'b0;
    kind_nxt         = pbfd_pkg::KIND_NONE;
    res_nxt          = '0;
    res_nxt.command_code = pbfd_pkg::CMD_RECALL;
    case (mode_r)
      pbfd_pkg::MODE_DATA: begin
        if (frame_open_r) begin
          if (frame_count_r >= FULL) begin
            frame_bad_nxt = 1'b1;
          end else begin
            byte_we         = 1'b1;
            frame_count_nxt = frame_count_r + CNT_W'(1);
          end
        end
      end
      pbfd_pkg::MODE_START: begin
        if (frame_open_r && frame_count_r != '0) begin
          kind_nxt         = pbfd_pkg::KIND_DROP;
          res_nxt.argument = 8'(frame_count_r);
        end
        frame_open_nxt  = 1'b1;
        frame_count_nxt = '0;
        frame_bad_nxt   = 1'b0;
      end
      pbfd_pkg::MODE_STOP: begin
        if (frame_open_r && frame_count_r != '0) begin
          if (!frame_bad_r) begin
            kind_nxt = pbfd_pkg::KIND_CMD;
            res_nxt  = dec;
            if (eff.remote_set) remote_state_nxt = 1'b1;
            if (eff.remote_clr) remote_state_nxt = 1'b0;
            if (eff.reply_set)  reply_flag_nxt   = 1'b1;
            if (eff.job_set)    job_busy_nxt     = 1'b1;
          end else begin
            kind_nxt         = pbfd_pkg::KIND_DROP;
            res_nxt.argument = 8'(frame_count_r);
          end
        end
        frame_open_nxt  = 1'b0;
        frame_count_nxt = '0;
        frame_bad_nxt   = 1'b0;
      end
      pbfd_pkg::MODE_OVERFLOW:   frame_bad_nxt  = 1'b1;
      pbfd_pkg::MODE_JOB_DONE:   job_busy_nxt   = 1'b0;
      pbfd_pkg::MODE_REPLY_SENT: reply_flag_nxt = 1'b0;
      default: begin
      end
    endcase
    res_nxt.remote_on  = remote_state_nxt;
    res_nxt.reply_owed = reply_flag_nxt;
  end

  // frame and command state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r  <= '0;
      frame_open_r   <= 1'b0;
      frame_bad_r    <= 1'b0;
      remote_state_r <= remote_default_r;
      reply_flag_r   <= 1'b0;
      job_busy_r     <= 1'b0;
    end else if (advance) begin
      frame_count_r  <= frame_count_nxt;
      frame_open_r   <= frame_open_nxt;
      frame_bad_r    <= frame_bad_nxt;
      remote_state_r <= remote_state_nxt;
      reply_flag_r   <= reply_flag_nxt;
      job_busy_r     <= job_busy_nxt;
    end
  end

  // frame buffer, written at the fill position
  always_ff @(posedge clk) begin
    if (advance && byte_we) begin
      frame_bytes_r[frame_count_r[IDX_W-1:0]] <= byte_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_kind_r <= kind_nxt;
      out_res_r  <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = pbfd_pkg::OUT_TDATA_W'(out_res_r);

endmodule

`default_nettype wire

// ===== hw/rtl/pbfd_checker.sv =====
// Port-level checks for the preset bus frame decoder, bound to the top level.
// Depends on pbfd_pkg.
`default_nettype none

module pbfd_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_tvalid,
  input wire logic                        out_tready,
  input wire logic [pbfd_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic [1:0]                  out_tuser
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // strobes and job flags only come with a decoded command
  a_strobe_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[pbfd_pkg::POS_RECALL] || out_tdata[pbfd_pkg::POS_SAVE] ||
                   out_tdata[pbfd_pkg::POS_START] || out_tdata[pbfd_pkg::POS_REFUSED])
    |-> out_tuser == pbfd_pkg::KIND_CMD)
    else $error("strobe without a decoded command");

  // a preset strobe needs remote enable
  a_strobe_remote: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[pbfd_pkg::POS_RECALL] || out_tdata[pbfd_pkg::POS_SAVE])
    |-> out_tdata[pbfd_pkg::POS_REMOTE])
    else $error("preset strobe while remote disabled");

  // a transfer is either started or refused, never both
  a_job_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[pbfd_pkg::POS_START] && out_tdata[pbfd_pkg::POS_REFUSED]))
    else $error("job started and refused together");

endmodule

bind preset_bus_frame_decoder_core pbfd_checker u_pbfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
